@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions clocked on clk and reset by rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

@@ src/mm2_pkg.sv @@
// ----------------------------------------------------------------------------
// MurmurHash2 package
// Constants, sequencer states and control/status structs of the hash block.
// ----------------------------------------------------------------------------
package mm2_pkg;

    // MurmurHash2 mixing constants.
    localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
    localparam int          MIX_SHIFT   = 24;
    localparam int          FIN_SHIFT_A = 13;
    localparam int          FIN_SHIFT_B = 15;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,  // waiting for an input transfer
        ST_K1,    // multiply data word
        ST_K2,    // multiply shifted word mix
        ST_H,     // multiply running hash
        ST_HX,    // combine hash with word mix
        ST_T,     // multiply hash with tail bytes
        ST_TX,    // store tail product
        ST_F,     // multiply for final avalanche
        ST_FX     // final shift, load output register
    } mm2_state_t;

    // Multiplier operand select.
    typedef enum logic [2:0] {
        OP_WORD,
        OP_KMIX,
        OP_HASH,
        OP_TAIL,
        OP_FIN
    } mm2_op_t;

    // Controls from the sequencer to the datapath.
    typedef struct packed {
        logic    in_ready;
        logic    mul_en;
        mm2_op_t op_sel;
        logic    k_load;
        logic    h_mix;
        logic    h_prod;
        logic    left_sub4;
        logic    left_clr;
        logic    out_load;
    } mm2_ctrl_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic in_valid;
        logic first;
        logic eff_zero;
        logic eff_ge4;
        logic left_last4;
        logic out_free;
    } mm2_stat_t;

endpackage

@@ src/mm2_mul.sv @@
// ----------------------------------------------------------------------------
// MurmurHash2 shared multiplier
// Multiplies one 32-bit operand by the mixing constant, product registered.
// ----------------------------------------------------------------------------
module mm2_mul
    import mm2_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] operand,
    output logic [31:0] product
);

    logic [31:0] product_reg;
    logic [31:0] product_next;

    // Only the low 32 bits of the product are kept.
    assign product_next = operand * MIX_MUL;

    // Product register, updated only when the sequencer issues an operation.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            product_reg <= product_next;
        end
    end

    assign product = product_reg;

endmodule

@@ src/mm2_seq.sv @@
// ----------------------------------------------------------------------------
// MurmurHash2 sequencer
// Steps the shared multiplier through word mix, tail mix and final avalanche.
// ----------------------------------------------------------------------------
module mm2_seq
    import mm2_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  mm2_stat_t stat,
    output mm2_ctrl_t ctrl
);

    mm2_state_t state_reg;
    mm2_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and controls.
    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        ctrl.op_sel = OP_WORD;
        case (state_reg)
            ST_IDLE:
            begin
                ctrl.in_ready = 1'b1;
                if (stat.in_valid)
                begin
                    // A stray word with no open message is consumed without starting any work.
                    if (stat.eff_zero)
                    begin
                        state_next = stat.first ? ST_F : ST_IDLE;
                    end
                    else if (stat.eff_ge4)
                    begin
                        state_next = ST_K1;
                    end
                    else
                    begin
                        state_next = ST_T;
                    end
                end
            end
            ST_K1:
            begin
                ctrl.mul_en = 1'b1;
                ctrl.op_sel = OP_WORD;
                state_next  = ST_K2;
            end
            ST_K2:
            begin
                ctrl.mul_en = 1'b1;
                ctrl.op_sel = OP_KMIX;
                state_next  = ST_H;
            end
            ST_H:
            begin
                ctrl.k_load = 1'b1;
                ctrl.mul_en = 1'b1;
                ctrl.op_sel = OP_HASH;
                state_next  = ST_HX;
            end
            ST_HX:
            begin
                ctrl.h_mix     = 1'b1;
                ctrl.left_sub4 = 1'b1;
                state_next     = stat.left_last4 ? ST_F : ST_IDLE;
            end
            ST_T:
            begin
                ctrl.mul_en   = 1'b1;
                ctrl.op_sel   = OP_TAIL;
                ctrl.left_clr = 1'b1;
                state_next    = ST_TX;
            end
            ST_TX:
            begin
                ctrl.h_prod = 1'b1;
                state_next  = ST_F;
            end
            ST_F:
            begin
                ctrl.mul_en = 1'b1;
                ctrl.op_sel = OP_FIN;
                state_next  = ST_FX;
            end
            ST_FX:
            begin
                // Hold the product until the output register is free.
                if (stat.out_free)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ src/murmur2_message_hash.sv @@
// ----------------------------------------------------------------------------
// MurmurHash2 message hash
// Streaming 32-bit MurmurHash2 over little-endian words with a seed register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries first_word, message_length and
//   data_word. A transfer with first_word set opens a message, seeds the hash
//   with hash_seed XOR message_length and consumes its own data word. Later
//   words are consumed until the byte count is used up; a final partial word
//   holds its bytes in the low positions. Words with first_word clear and no
//   open message are dropped. A zero-length message finishes on its first word.
//   The result leaves on hash_valid/hash_ready from an output register.
//   Configuration: hash_seed is written by a cfg_valid/cfg_ready transfer,
//   always ready; write it only while the block is idle.
//   Sequence: one multiplier is shared by every step. A full word passes
//   through accept, three multiplies and a combine step; a tail word through
//   accept, a multiply and a store. The finish adds a multiply and a final
//   shift into the output register. in_ready is low while a word is at work.
//   A stalled receiver holds the result; the block still takes the next
//   message's words and waits in its last step only if a second result is
//   ready before the first is taken.
//   Reset clears the seed, the running hash, the byte count and hash_valid.
// ----------------------------------------------------------------------------
module murmur2_message_hash
    import mm2_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] hash_seed,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        first_word,
    input  logic [31:0] message_length,
    input  logic [31:0] data_word,
    output logic        hash_valid,
    input  logic        hash_ready,
    output logic [31:0] hash_value
);

    mm2_ctrl_t   ctrl;
    mm2_stat_t   stat;
    logic        in_fire;
    logic [31:0] eff_len;
    logic [31:0] tail_mask;
    logic [31:0] operand;
    logic [31:0] product;

    logic [31:0] seed_reg;
    logic [31:0] seed_next;
    logic [31:0] hash_reg;
    logic [31:0] hash_next;
    logic [31:0] left_reg;
    logic [31:0] left_next;
    logic [31:0] word_reg;
    logic [31:0] word_next;
    logic [31:0] kmix_reg;
    logic [31:0] kmix_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] out_reg;
    logic [31:0] out_next;

    // Handshakes and status for the sequencer.
    assign cfg_ready = 1'b1;
    assign in_ready  = ctrl.in_ready;
    assign in_fire   = in_valid && ctrl.in_ready;
    assign eff_len   = first_word ? message_length : left_reg;

    always_comb
    begin
        stat.in_valid   = in_valid;
        stat.first      = first_word;
        stat.eff_zero   = (eff_len == 32'd0);
        stat.eff_ge4    = |eff_len[31:2];
        stat.left_last4 = (left_reg == 32'd4);
        stat.out_free   = !out_valid_reg || hash_ready;
    end

    // Mask of the valid tail bytes in a partial word.
    always_comb
    begin
        case (left_reg[1:0])
            2'd3:    tail_mask = 32'h00FF_FFFF;
            2'd2:    tail_mask = 32'h0000_FFFF;
            default: tail_mask = 32'h0000_00FF;
        endcase
    end

    // Operand select for the shared multiplier.
    always_comb
    begin
        case (ctrl.op_sel)
            OP_WORD: operand = word_reg;
            OP_KMIX: operand = product ^ (product >> MIX_SHIFT);
            OP_HASH: operand = hash_reg;
            OP_TAIL: operand = hash_reg ^ (word_reg & tail_mask);
            OP_FIN:  operand = hash_reg ^ (hash_reg >> FIN_SHIFT_A);
            default: operand = word_reg;
        endcase
    end

    mm2_mul u_mul (
        .clk     (clk),
        .en      (ctrl.mul_en),
        .operand (operand),
        .product (product)
    );

    mm2_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    // Next values of the datapath registers.
    always_comb
    begin
        seed_next      = seed_reg;
        hash_next      = hash_reg;
        left_next      = left_reg;
        word_next      = word_reg;
        kmix_next      = kmix_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (cfg_valid)
        begin
            seed_next = hash_seed;
        end

        // A first word restarts the hash and the byte count.
        if (in_fire)
        begin
            word_next = data_word;
            if (first_word)
            begin
                hash_next = seed_reg ^ message_length;
                left_next = message_length;
            end
        end

        if (ctrl.k_load)
        begin
            kmix_next = product;
        end
        if (ctrl.h_mix)
        begin
            hash_next = product ^ kmix_reg;
        end
        if (ctrl.h_prod)
        begin
            hash_next = product;
        end
        if (ctrl.left_sub4)
        begin
            left_next = left_reg - 32'd4;
        end
        if (ctrl.left_clr)
        begin
            left_next = 32'd0;
        end

        // Output register: cleared on transfer, loaded by the final step.
        if (out_valid_reg && hash_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (ctrl.out_load)
        begin
            out_next       = product ^ (product >> FIN_SHIFT_B);
            out_valid_next = 1'b1;
        end
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= 32'd0;
            hash_reg      <= 32'd0;
            left_reg      <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seed_reg      <= seed_next;
            hash_reg      <= hash_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        kmix_reg <= kmix_next;
        out_reg  <= out_next;
    end

    assign hash_valid = out_valid_reg;
    assign hash_value = out_reg;

endmodule

@@ src/mm2_checker.sv @@
// ----------------------------------------------------------------------------
// MurmurHash2 port checker
// Watches the top-level ports of the hash block over time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mm2_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic        in_valid,
    input logic        in_ready,
    input logic        first_word,
    input logic        hash_valid,
    input logic        hash_ready,
    input logic [31:0] hash_value
);

    // A stalled result keeps its value.
    `ASSERT_CLK(a_out_hold, hash_valid && !hash_ready |=> hash_valid && $stable(hash_value), "result changed while stalled")

    // A first word always starts work, so the block is busy afterwards.
    `ASSERT_CLK(a_first_busy, in_valid && in_ready && first_word |=> !in_ready, "first word did not start work")

    // Ready only drops after an input transfer.
    `ASSERT_CLK(a_ready_drop, $fell(in_ready) |-> $past(in_valid), "ready dropped without a transfer")

    // A new result appears only when the sequencer is back at rest.
    `ASSERT_CLK(a_result_idle, $rose(hash_valid) |-> in_ready, "result raised while busy")

    // The configuration port never stalls.
    `ASSERT_NEVER(a_cfg_stall, cfg_valid && !cfg_ready, "configuration write stalled")

endmodule

bind murmur2_message_hash mm2_checker u_mm2_checker (.*);

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MurmurHash2 message hash testbench
// Feeds messages of many lengths, under several seed values, through the
// streaming hash block. The predictor below mirrors the hash state, and every
// hash that leaves the block is checked against it in order. A directed
// opening covers empty messages, each tail size, ignored words and restarts.
// A random body follows it, with random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench
    import mm2_pkg::*;
();

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned SETTLE_CYCLES  = 20;
    localparam int unsigned PHASE_WORDS    = 205;

    // One input transfer: the three payload fields.
    typedef struct {
        logic        first;
        logic [31:0] length;
        logic [31:0] word;
    } hash_word_t;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        cfg_valid      = 1'b0;
    logic        cfg_ready;
    logic [31:0] hash_seed      = 32'h0;
    logic        in_valid       = 1'b0;
    logic        in_ready;
    logic        first_word     = 1'b0;
    logic [31:0] message_length = 32'h0;
    logic [31:0] data_word      = 32'h0;
    logic        hash_valid;
    logic        hash_ready     = 1'b0;
    logic [31:0] hash_value;

    // Stimulus and expected results.
    hash_word_t  word_queue[$];
    logic [31:0] expected_hashes[$];

    // Predictor state.
    logic [31:0] seed_copy  = 32'h0;
    logic [31:0] hash_acc   = 32'h0;
    logic [31:0] left_bytes = 32'h0;
    bit          msg_open   = 1'b0;

    int unsigned error_count = 0;
    int unsigned in_gap      = 0;
    int unsigned out_gap     = 0;
    int unsigned quiet_count = 0;
    bit          rush_in     = 1'b0;
    bit          rush_out    = 1'b0;

    murmur2_message_hash u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .hash_seed      (hash_seed),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .first_word     (first_word),
        .message_length (message_length),
        .data_word      (data_word),
        .hash_valid     (hash_valid),
        .hash_ready     (hash_ready),
        .hash_value     (hash_value)
    );

    always #1 clk = ~clk;

    // Wait before the next transfer; now and then switch to a run with no gaps.
    function automatic int unsigned pick_wait(inout bit rush);
        if ($urandom_range(0, 31) == 0)
            rush = !rush;
        return rush ? 0 : $urandom_range(0, 12);
    endfunction

    // Final avalanche of the hash.
    function automatic logic [31:0] avalanche(input logic [31:0] h);
        logic [31:0] x;
        x = h ^ (h >> FIN_SHIFT_A);
        x = x * MIX_MUL;
        return x ^ (x >> FIN_SHIFT_B);
    endfunction

    // Advance the predicted hash by one accepted transfer.
    task automatic predict_hash(input logic first, input logic [31:0] length,
                                input logic [31:0] word);
        logic [31:0] k;
        logic [31:0] h;
        logic [31:0] keep;
        if (first) begin
            hash_acc   = seed_copy ^ length;
            left_bytes = length;
            msg_open   = 1'b1;
            if (length == 0) begin
                msg_open = 1'b0;
                expected_hashes.push_back(avalanche(hash_acc));
                return;
            end
        end else if (!msg_open) begin
            return;
        end
        h = hash_acc;
        if (left_bytes >= 4) begin
            k = word * MIX_MUL;
            k = k ^ (k >> MIX_SHIFT);
            k = k * MIX_MUL;
            h = (h * MIX_MUL) ^ k;
            left_bytes = left_bytes - 4;
        end else begin
            // Only the remaining tail bytes of the partial word count.
            case (left_bytes)
                3:       keep = 32'h00FF_FFFF;
                2:       keep = 32'h0000_FFFF;
                default: keep = 32'h0000_00FF;
            endcase
            h = (h ^ (word & keep)) * MIX_MUL;
            left_bytes = 0;
        end
        hash_acc = h;
        if (left_bytes == 0) begin
            msg_open = 1'b0;
            expected_hashes.push_back(avalanche(h));
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h, expected %h", what, got, want);
        error_count++;
    endtask

    function automatic void push_word(input logic first, input logic [31:0] length,
                                      input logic [31:0] word);
        hash_word_t w;
        w.first  = first;
        w.length = length;
        w.word   = word;
        word_queue.push_back(w);
    endfunction

    // Queue a complete message with random content; returns its word count.
    function automatic int unsigned queue_message(input logic [31:0] length);
        int unsigned n;
        n = (length == 0) ? 1 : (length + 3) / 4;
        push_word(1'b1, length, $urandom());
        for (int unsigned i = 1; i < n; i++)
            push_word(1'b0, $urandom(), $urandom());
        return n;
    endfunction

    // Mostly whole messages, with abandoned openings and ignored words mixed in.
    task automatic queue_random_traffic(input int unsigned count);
        int unsigned added;
        int unsigned pick;
        int unsigned extra;
        logic [31:0] length;
        added = 0;
        while (added < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                push_word(1'b0, $urandom(), $urandom());
            end else if (pick < 18) begin
                // A long message cut short by the next opening word.
                extra = $urandom_range(0, 2);
                push_word(1'b1, $urandom() | 32'h0000_0100, $urandom());
                for (int unsigned i = 0; i < extra; i++)
                    push_word(1'b0, $urandom(), $urandom());
                added += extra + 1;
            end else begin
                length = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 128)
                                                     : $urandom_range(0, 24);
                added += queue_message(length);
            end
        end
        added += queue_message($urandom_range(1, 24));
    endtask

    // Let all queued words go out and all hashes come back, then settle.
    task automatic wait_idle();
        while (word_queue.size() != 0 || in_valid || expected_hashes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_seed(input logic [31:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        hash_seed <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Input driver: presents queued words with random gaps between them.
    always @(posedge clk or negedge rst_n) begin : word_driver
        hash_word_t nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_gap   <= 0;
        end else if (!in_valid || in_ready) begin
            if (in_gap > 0) begin
                in_valid <= 1'b0;
                in_gap   <= in_gap - 1;
            end else if (word_queue.size() > 0) begin
                nxt = word_queue.pop_front();
                in_valid       <= 1'b1;
                first_word     <= nxt.first;
                message_length <= nxt.length;
                data_word      <= nxt.word;
                in_gap         <= pick_wait(rush_in);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each hash transfer, predicts from each input transfer,
    // tracks seed writes, and stalls the result channel at random.
    always @(posedge clk or negedge rst_n) begin : hash_monitor
        logic [31:0] want;
        int unsigned wait_n;
        if (!rst_n) begin
            hash_ready <= 1'b0;
            out_gap    <= 0;
        end else begin
            if (hash_valid && hash_ready) begin
                if (expected_hashes.size() == 0) begin
                    report_mismatch("hash_value with no message pending", hash_value, 32'h0);
                end else begin
                    want = expected_hashes.pop_front();
                    if (hash_value !== want)
                        report_mismatch("hash_value", hash_value, want);
                end
                wait_n = pick_wait(rush_out);
                out_gap    <= wait_n;
                hash_ready <= (wait_n == 0);
            end else if (out_gap > 0) begin
                out_gap    <= out_gap - 1;
                hash_ready <= (out_gap == 1);
            end else begin
                hash_ready <= 1'b1;
            end
            if (in_valid && in_ready)
                predict_hash(first_word, message_length, data_word);
            if (cfg_valid && cfg_ready)
                seed_copy = hash_seed;
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (hash_valid && hash_ready) ||
                (cfg_valid && cfg_ready)) begin
                quiet_count <= 0;
            end else if (quiet_count + 1 >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end else begin
                quiet_count <= quiet_count + 1;
            end
        end
    end

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening under the reset seed.
        push_word(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);   // ignored, nothing open
        push_word(1'b1, 32'h0,         32'hFFFF_FFFF);   // empty message
        push_word(1'b1, 32'd1,         32'hFFFF_FFFF);   // one tail byte
        push_word(1'b1, 32'd2,         32'hA5A5_A5A5);   // two tail bytes
        push_word(1'b1, 32'd3,         32'hFFFF_FFFF);   // three tail bytes
        push_word(1'b1, 32'd4,         32'hFFFF_FFFF);   // one full word
        push_word(1'b1, 32'd4,         32'h0000_0000);
        push_word(1'b1, 32'd8,         32'h1234_5678);   // two full words
        push_word(1'b0, 32'hFFFF_FFFF, 32'h9ABC_DEF0);
        push_word(1'b1, 32'd7,         32'h0F0F_0F0F);   // full word then tail
        push_word(1'b0, 32'h5555_5555, 32'hFFFF_FFFF);
        push_word(1'b1, 32'd12,        32'hDEAD_BEEF);   // restarted mid-message
        push_word(1'b0, 32'h0,         32'hCAFE_F00D);
        push_word(1'b1, 32'd5,         32'h0102_0304);
        push_word(1'b0, 32'hAAAA_AAAA, 32'hFFFF_FF80);
        push_word(1'b1, 32'hFFFF_FFFF, 32'h8000_0001);   // longest length, abandoned
        push_word(1'b0, 32'h0,         32'h7FFF_FFFE);
        push_word(1'b1, 32'd4,         32'h8000_0000);
        push_word(1'b0, 32'h0,         32'h0000_0000);   // ignored again
        queue_random_traffic(PHASE_WORDS);
        wait_idle();

        // Seed phases, the extremes among them.
        write_seed(32'hFFFF_FFFF);
        queue_random_traffic(PHASE_WORDS);
        wait_idle();
        write_seed($urandom());
        queue_random_traffic(PHASE_WORDS);
        wait_idle();
        write_seed(32'h0000_0000);
        queue_random_traffic(PHASE_WORDS);
        wait_idle();
        write_seed(32'h8000_0001);
        queue_random_traffic(PHASE_WORDS);
        wait_idle();

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
